FILE: hdl/sfd_pkg.sv
// sfd_pkg: types, register indexes, status codes and reset constants
// for the sensor frame deframer. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int WORD_COUNT_DEFAULT = 16;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'h42;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'h4D;

    localparam logic [5:0] COUNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_SUM    = 2'd2,
        STATUS_SHORT      = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic [3:0]  word_index;
        logic [15:0] word_value;
        status_t     status;
        logic        last_word;
    } result_t;

    typedef struct packed {
        logic take;
        logic burst_active;
    } emit_state_t;

endpackage

FILE: hdl/sfd_parser.sv
// sfd_parser: header check, byte count, running sum, word capture and
// frame verdict. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_parser
    import sfd_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  item_t                  item,
    input  logic                   take,
    input  logic [3:0]             rd_addr,
    output logic [15:0]            rd_data,
    output status_t                verdict
);

    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [5:0] MIN_POS   = 6'(2 * WORD_COUNT + 3);
    localparam logic [5:0] LAST_WPOS = 6'(2 * WORD_COUNT + 1);

    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;
    logic [5:0]  byte_count_reg, byte_count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  prev_reg, prev_next;
    logic        header_good_reg, header_good_next;
    logic [15:0] store_reg [WORD_COUNT];

    logic [15:0] pair;
    logic        capture;
    logic [5:0]  wpos;

    assign pair    = {prev_reg, item.rx_byte};
    assign capture = (byte_count_reg >= 6'd3) && byte_count_reg[0]
                     && (byte_count_reg <= LAST_WPOS);
    assign wpos    = (byte_count_reg - 6'd3) >> 1;
    assign rd_data = store_reg[rd_addr[AW-1:0]];

    always_comb
    begin
        if (byte_count_reg < MIN_POS)
            verdict = STATUS_SHORT;
        else if (!header_good_reg)
            verdict = STATUS_BAD_HEADER;
        else if (sum_reg != pair)
            verdict = STATUS_BAD_SUM;
        else
            verdict = STATUS_OK;
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        sum_next         = sum_reg;
        prev_next        = prev_reg;
        header_good_next = header_good_reg;
        if (take)
        begin
            if (item.frame_end)
            begin
                byte_count_next  = '0;
                sum_next         = '0;
                prev_next        = '0;
                header_good_next = 1'b0;
            end
            else
            begin
                if (byte_count_reg == 6'd1)
                    header_good_next = (prev_reg == header_first_reg)
                                       && (item.rx_byte == header_second_reg);
                if (byte_count_reg != 6'd0)
                    sum_next = sum_reg + {8'd0, prev_reg};
                prev_next = item.rx_byte;
                if (byte_count_reg < COUNT_MAX)
                    byte_count_next = byte_count_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
            byte_count_reg    <= '0;
            sum_reg           <= '0;
            prev_reg          <= '0;
            header_good_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_HEADER_FIRST))
                header_first_reg <= cfg_data;
            if (cfg_write && (cfg_index == REG_HEADER_SECOND))
                header_second_reg <= cfg_data;
            byte_count_reg  <= byte_count_next;
            sum_reg         <= sum_next;
            prev_reg        <= prev_next;
            header_good_reg <= header_good_next;
        end
    end

    // word store, no reset: every word is written before a good frame reads it
    always_ff @(posedge clk)
    begin
        if (take && capture)
            store_reg[wpos[AW-1:0]] <= pair;
    end

endmodule

FILE: hdl/sfd_emitter.sv
// sfd_emitter: transaction control, word burst sequencer and result
// register. Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_emitter
    import sfd_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pend_valid,
    input  logic        pend_end,
    input  status_t     verdict,
    input  logic [15:0] rd_data,
    output logic [3:0]  rd_addr,
    output emit_state_t state,
    input  logic        result_stall,
    output logic        result_valid,
    output result_t     result
);

    localparam logic [3:0] LAST_IDX = 4'(WORD_COUNT - 1);

    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;
    logic       burst_active_reg, burst_active_next;
    logic [3:0] burst_idx_reg, burst_idx_next;

    logic out_free;
    logic take;
    logic load_first;
    logic load_word;

    assign out_free   = !out_valid_reg || !result_stall;
    assign take       = pend_valid && !burst_active_reg && (!pend_end || out_free);
    assign load_first = take && pend_end;
    assign load_word  = burst_active_reg && out_free;
    assign rd_addr    = burst_active_reg ? burst_idx_reg : 4'd0;

    always_comb
    begin
        out_valid_next    = out_valid_reg && result_stall;
        out_data_next     = out_data_reg;
        burst_active_next = burst_active_reg;
        burst_idx_next    = burst_idx_reg;
        if (load_word)
        begin
            out_valid_next           = 1'b1;
            out_data_next.word_index = burst_idx_reg;
            out_data_next.word_value = rd_data;
            out_data_next.status     = STATUS_OK;
            out_data_next.last_word  = (burst_idx_reg == LAST_IDX);
            if (burst_idx_reg == LAST_IDX)
                burst_active_next = 1'b0;
            else
                burst_idx_next = burst_idx_reg + 4'd1;
        end
        else if (load_first)
        begin
            out_valid_next           = 1'b1;
            out_data_next.word_index = 4'd0;
            out_data_next.status     = verdict;
            if (verdict == STATUS_OK)
            begin
                out_data_next.word_value = rd_data;
                out_data_next.last_word  = (LAST_IDX == 4'd0);
                if (LAST_IDX != 4'd0)
                begin
                    burst_active_next = 1'b1;
                    burst_idx_next    = 4'd1;
                end
            end
            else
            begin
                out_data_next.word_value = '0;
                out_data_next.last_word  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            burst_active_reg <= 1'b0;
            burst_idx_reg    <= '0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            burst_active_reg <= burst_active_next;
            burst_idx_reg    <= burst_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign state.take         = take;
    assign state.burst_active = burst_active_reg;
    assign result_valid       = out_valid_reg;
    assign result             = out_data_reg;

endmodule

FILE: hdl/sensor_frame_deframer_unit.sv
// sensor_frame_deframer_unit: top level; input register, parser and emitter.
// Depends on sfd_pkg, sfd_parser and sfd_emitter.
`timescale 1ns / 1ps

// Takes one frame byte per cycle while item_stall is low. A byte passes
// through the input register and is consumed from there; bytes that end no
// frame never wait on the result side. The final byte of a frame yields one
// result: an error status, or on a good frame the first of WORD_COUNT words,
// which then leave the result register one per cycle while result_stall is
// low. During that burst the word sequencer owns the result register and
// bytes wait in the input register. Header bytes are configurable through
// cfg_write/cfg_index/cfg_data while the block is idle, a user duty.

module sensor_frame_deframer_unit
    import sfd_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    logic        pend_valid_reg, pend_valid_next;
    item_t       pend_reg;
    logic        item_fire;
    emit_state_t emit_state;
    status_t     verdict;
    logic [3:0]  rd_addr;
    logic [15:0] rd_data;

    assign item_stall      = pend_valid_reg && !emit_state.take;
    assign item_fire       = item_valid && !item_stall;
    assign pend_valid_next = item_fire || (pend_valid_reg && !emit_state.take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else
            pend_valid_reg <= pend_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            pend_reg <= item;
    end

    sfd_parser #(
        .WORD_COUNT (WORD_COUNT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (pend_reg),
        .take      (emit_state.take),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .verdict   (verdict)
    );

    sfd_emitter #(
        .WORD_COUNT (WORD_COUNT)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .pend_valid   (pend_valid_reg),
        .pend_end     (pend_reg.frame_end),
        .verdict      (verdict),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .state        (emit_state),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // no byte is consumed while a word burst holds the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_state.take |-> !emit_state.burst_active)
        else $error("byte consumed during word burst");

    // error results are single and carry index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != STATUS_OK))
            |-> (result.last_word && (result.word_index == 4'd0)))
        else $error("malformed error result");

    // a burst continues without a gap, indexes counting up
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last_word)
            |=> (result_valid && (result.word_index == $past(result.word_index) + 4'd1)))
        else $error("word burst broken");

endmodule
